// ===== hw/rtl/tksle_pkg.sv =====
// tksle_pkg: types and byte codes for the terminal key sequence line editor
// no dependencies; imported by terminal_key_sequence_line_editor_top

package tksle_pkg;

	// escape decoder phase
	typedef enum logic [2:0] {
		PH_NONE  = 3'd0,
		PH_ESC   = 3'd1,
		PH_CSI   = 3'd2,
		PH_PARAM = 3'd3,
		PH_SS3   = 3'd4
	} phase_t;

	// edit action reported to the line memory
	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_INSERT = 3'd1,
		ACT_DELETE = 3'd2,
		ACT_MOVE   = 3'd3,
		ACT_DONE   = 3'd4,
		ACT_EOF    = 3'd5,
		ACT_PREV   = 3'd6,
		ACT_NEXT   = 3'd7
	} action_t;

	// item kinds
	typedef enum logic [1:0] {
		MODE_BYTE    = 2'd0,
		MODE_TIMEOUT = 2'd1,
		MODE_INSTALL = 2'd2,
		MODE_UNUSED  = 2'd3
	} mode_t;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_EOT   = 8'h04;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_SS3   = 8'h4F;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP    = 8'h41;
	localparam logic [7:0] CH_DOWN  = 8'h42;
	localparam logic [7:0] CH_RIGHT = 8'h43;
	localparam logic [7:0] CH_LEFT  = 8'h44;
	localparam logic [7:0] CH_HOME  = 8'h48;
	localparam logic [7:0] CH_END   = 8'h46;

	localparam logic [7:0] CAP_RESET = 8'd100;
	localparam logic [7:0] NUM_MAX   = 8'd255;

endpackage

// ===== hw/rtl/terminal_key_sequence_line_editor_top.sv =====
// terminal_key_sequence_line_editor_top: escape sequence decoder and line edit tracker
// depends on tksle_pkg (phase, action and mode codes, byte constants)
//
// channel  direction  handshake              payload
// in       to block   in_valid / in_ready    mode, byte_value, recall_length, restore_draft
// out      from block out_valid / out_ready  action, char_value, cursor_col, line_len
// cfg      to block   cfg_we (no wait)       cfg_data -> buffer capacity
//
// one item per cycle sustained while out_ready stays high; the result passes from the input
// transfer through the input register, then decode and edit update into the result register
// the decoder and edit state are updated as the item leaves the input register
// out_ready low holds the result register, then the input register, then in_ready drops
// reset clears the editor state and sets the buffer capacity to 100; no clearing pass

module terminal_key_sequence_line_editor_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] byte_value,
	input  logic [7:0] recall_length,
	input  logic       restore_draft,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] action,
	output logic [7:0] char_value,
	output logic [7:0] cursor_col,
	output logic [7:0] line_len,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data
);
	import tksle_pkg::*;

	// input register
	logic       valid_s1;
	mode_t      mode_s1;
	logic [7:0] byte_s1;
	logic [7:0] recall_s1;
	logic       restore_s1;

	// result register
	logic       out_valid_q;
	action_t    action_q;
	logic [7:0] char_q;
	logic [7:0] cursor_q;
	logic [7:0] length_q;

	// editor state
	logic [7:0] capacity_q;
	phase_t     phase_q;
	logic [7:0] number_q;
	logic [7:0] length_st_q;
	logic [7:0] cursor_st_q;
	logic [7:0] draft_q;
	logic       on_draft_q;

	// next state and result
	phase_t     phase_d;
	logic [7:0] number_d;
	logic [7:0] length_d;
	logic [7:0] cursor_d;
	logic [7:0] draft_d;
	logic       on_draft_d;
	action_t    act_d;
	logic [7:0] char_d;
	logic [7:0] rep_cursor_d;
	logic [7:0] rep_length_d;

	logic        advance;
	logic        in_xfer;
	logic        is_digit;
	logic [7:0]  digit_val;
	logic [8:0]  len_plus2;
	logic [7:0]  limit;
	logic [7:0]  clamp_len;
	logic [11:0] num_next;

	// the input register moves on when the result register is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_s1    <= mode_t'(mode);
			byte_s1    <= byte_value;
			recall_s1  <= recall_length;
			restore_s1 <= restore_draft;
		end
	end

	// shared helpers for the decode
	assign is_digit  = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign digit_val = byte_s1 - CH_ZERO;
	assign len_plus2 = {1'b0, length_st_q} + 9'd2;
	assign limit     = (capacity_q >= 8'd2) ? (capacity_q - 8'd2) : 8'd0;
	assign clamp_len = (recall_s1 > limit) ? limit : recall_s1;
	// decimal parameter accumulate, saturating later
	assign num_next  = ({4'd0, number_q} * 12'd10) + {4'd0, digit_val};

	always_comb begin
		phase_d    = phase_q;
		number_d   = number_q;
		length_d   = length_st_q;
		cursor_d   = cursor_st_q;
		draft_d    = draft_q;
		on_draft_d = on_draft_q;
		act_d      = ACT_NONE;
		char_d     = 8'd0;

		unique case (mode_s1)
			MODE_BYTE: begin
				if (phase_q == PH_NONE) begin
					// plain keys
					if (byte_s1 == CH_ESC) begin
						phase_d = PH_ESC;
					end else if (byte_s1 == CH_CR || byte_s1 == CH_LF) begin
						act_d = ACT_DONE;
					end else if (byte_s1 == CH_DEL || byte_s1 == CH_BS) begin
						if (cursor_st_q != 8'd0) begin
							cursor_d = cursor_st_q - 8'd1;
							length_d = length_st_q - 8'd1;
							act_d    = ACT_DELETE;
						end
					end else if (byte_s1 == CH_EOT) begin
						if (length_st_q == 8'd0) begin
							act_d = ACT_EOF;
						end
					end else if (byte_s1 >= CH_SPACE && len_plus2 < {1'b0, capacity_q}) begin
						cursor_d = cursor_st_q + 8'd1;
						length_d = length_st_q + 8'd1;
						char_d   = byte_s1;
						act_d    = ACT_INSERT;
					end
				end else begin
					// inside a sequence: any byte ends the phase unless kept below
					phase_d = PH_NONE;
					unique case (phase_q)
						PH_ESC: begin
							if (byte_s1 == CH_LBRK) begin
								phase_d  = PH_CSI;
								number_d = 8'd0;
							end else if (byte_s1 == CH_SS3) begin
								phase_d = PH_SS3;
							end
						end
						PH_CSI: begin
							if (byte_s1 == CH_UP) begin
								if (on_draft_q) begin
									draft_d = cursor_st_q;
								end
								act_d = ACT_PREV;
							end else if (byte_s1 == CH_DOWN) begin
								act_d = ACT_NEXT;
							end else if (byte_s1 == CH_RIGHT) begin
								if (cursor_st_q < length_st_q) begin
									cursor_d = cursor_st_q + 8'd1;
								end
								act_d = ACT_MOVE;
							end else if (byte_s1 == CH_LEFT) begin
								if (cursor_st_q != 8'd0) begin
									cursor_d = cursor_st_q - 8'd1;
								end
								act_d = ACT_MOVE;
							end else if (byte_s1 == CH_HOME) begin
								cursor_d = 8'd0;
								act_d    = ACT_MOVE;
							end else if (byte_s1 == CH_END) begin
								cursor_d = length_st_q;
								act_d    = ACT_MOVE;
							end else if (is_digit) begin
								number_d = digit_val;
								phase_d  = PH_PARAM;
							end
						end
						PH_PARAM: begin
							if (is_digit) begin
								number_d = (num_next > {4'd0, NUM_MAX}) ? NUM_MAX : num_next[7:0];
								phase_d  = PH_PARAM;
							end else if (byte_s1 == CH_TILDE &&
									(number_q == 8'd1 || number_q == 8'd7)) begin
								cursor_d = 8'd0;
								act_d    = ACT_MOVE;
							end else if (byte_s1 == CH_TILDE &&
									(number_q == 8'd4 || number_q == 8'd8)) begin
								cursor_d = length_st_q;
								act_d    = ACT_MOVE;
							end
						end
						PH_SS3: begin
							if (byte_s1 == CH_HOME) begin
								cursor_d = 8'd0;
								act_d    = ACT_MOVE;
							end else if (byte_s1 == CH_END) begin
								cursor_d = length_st_q;
								act_d    = ACT_MOVE;
							end
						end
						default: begin
							phase_d = PH_NONE;
						end
					endcase
				end
			end
			MODE_TIMEOUT: begin
				// drop any half-read sequence
				phase_d = PH_NONE;
			end
			MODE_INSTALL: begin
				length_d = clamp_len;
				if (restore_s1) begin
					on_draft_d = 1'b1;
					cursor_d   = (draft_q < clamp_len) ? draft_q : clamp_len;
				end else begin
					on_draft_d = 1'b0;
					cursor_d   = clamp_len;
				end
			end
			default: begin
			end
		endcase

		rep_length_d = length_d;
		rep_cursor_d = cursor_d;

		// enter and end of input start a fresh line
		if (act_d == ACT_DONE || act_d == ACT_EOF) begin
			phase_d      = PH_NONE;
			number_d     = 8'd0;
			length_d     = 8'd0;
			cursor_d     = 8'd0;
			draft_d      = 8'd0;
			on_draft_d   = 1'b1;
			rep_cursor_d = 8'd0;
		end
	end

	// editor state and buffer capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			phase_q     <= PH_NONE;
			number_q    <= 8'd0;
			length_st_q <= 8'd0;
			cursor_st_q <= 8'd0;
			draft_q     <= 8'd0;
			on_draft_q  <= 1'b1;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_data;
			end
			if (advance) begin
				phase_q     <= phase_d;
				number_q    <= number_d;
				length_st_q <= length_d;
				cursor_st_q <= cursor_d;
				draft_q     <= draft_d;
				on_draft_q  <= on_draft_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q <= act_d;
			char_q   <= char_d;
			cursor_q <= rep_cursor_d;
			length_q <= rep_length_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign action     = action_q;
	assign char_value = char_q;
	assign cursor_col = cursor_q;
	assign line_len   = length_q;

endmodule
